[design/lsbmu_pkg.sv]
// ----------------------------------------------------------------------------
// lsbmu_pkg
// Types and codes shared by the load/store byte memory unit.
// ----------------------------------------------------------------------------
package lsbmu_pkg;

	localparam int ADDR_W    = 32;
	localparam int DATA_W    = 32;
	localparam int REG_W     = 5;
	localparam int CMD_W     = 4;
	localparam int STAT_W    = 2;
	localparam int RED_BITS  = 4;
	localparam int RED_STEPS = ADDR_W / RED_BITS;
	localparam int QDEPTH    = 2;

	localparam logic [CMD_W-1:0] CMD_LB   = 4'd0;
	localparam logic [CMD_W-1:0] CMD_LH   = 4'd1;
	localparam logic [CMD_W-1:0] CMD_LW   = 4'd2;
	localparam logic [CMD_W-1:0] CMD_LBU  = 4'd3;
	localparam logic [CMD_W-1:0] CMD_LHU  = 4'd4;
	localparam logic [CMD_W-1:0] CMD_SB   = 4'd5;
	localparam logic [CMD_W-1:0] CMD_SH   = 4'd6;
	localparam logic [CMD_W-1:0] CMD_SW   = 4'd7;
	localparam logic [CMD_W-1:0] CMD_PASS = 4'd8;

	localparam logic [STAT_W-1:0] ST_WB    = 2'd0;
	localparam logic [STAT_W-1:0] ST_STORE = 2'd1;
	localparam logic [STAT_W-1:0] ST_FAIL  = 2'd2;

	localparam logic [1:0] LAST_BYTE = 2'd0;
	localparam logic [1:0] LAST_HALF = 2'd1;
	localparam logic [1:0] LAST_WORD = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [REG_W-1:0]  dest_reg;
		logic [ADDR_W-1:0] byte_address;
		logic [DATA_W-1:0] data_value;
	} req_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [REG_W-1:0]  wb_reg;
		logic [DATA_W-1:0] wb_value;
	} rsp_t;

	typedef enum logic [1:0] {
		K_LOAD,
		K_STORE,
		K_PASS,
		K_FAIL
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [1:0]        last;
		logic              sgn;
		logic [REG_W-1:0]  dest;
		logic [DATA_W-1:0] data;
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_REDUCE,
		F_PUSH
	} fstate_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_LOAD,
		B_LWAIT,
		B_STORE,
		B_DONE
	} bstate_t;

endpackage

[design/lsbmu_queue.sv]
// ----------------------------------------------------------------------------
// lsbmu_queue
// Small first-in first-out queue of packed words.
// ----------------------------------------------------------------------------
module lsbmu_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);
	import lsbmu_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);

	logic [WIDTH-1:0] entry_q [QDEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(QDEPTH));
	assign empty   = (count_q == '0);
	assign rdata   = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("queue count beyond depth");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

endmodule

[design/lsbmu_front.sv]
// ----------------------------------------------------------------------------
// lsbmu_front
// Accepts a request, decodes its command and reduces its address modulo
// the memory size by summing per-nibble residues and folding the sum.
// ----------------------------------------------------------------------------
module lsbmu_front #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          hold,
	output logic                          full,
	input  lsbmu_pkg::req_t               request,
	output logic                          op_push,
	input  logic                          op_full,
	output lsbmu_pkg::op_t                op,
	output logic [$clog2(MEM_BYTES)-1:0]  op_base
);
	import lsbmu_pkg::*;

	localparam int AW       = $clog2(MEM_BYTES);
	localparam int SW       = AW + 3;
	localparam int NIB_VALS = 2 ** RED_BITS;

	typedef logic [RED_STEPS-1:0][NIB_VALS-1:0][AW-1:0] nib_tab_t;

	function automatic nib_tab_t nib_residues();
		nib_tab_t tab;
		longint   weight;
		tab    = '0;
		weight = 1;
		for (int j = 0; j < RED_STEPS; j++) begin
			for (int n = 0; n < NIB_VALS; n++)
				tab[j][n] = AW'((longint'(n) * weight) % MEM_BYTES);
			weight = (weight * NIB_VALS) % MEM_BYTES;
		end
		return tab;
	endfunction

	localparam nib_tab_t NIB_RES = nib_residues();

	fstate_t           state_q;
	fstate_t           state_d;
	req_t              req_q;
	logic [SW-1:0]     sum_d;
	logic [SW-1:0]     sum_q;
	logic [SW-1:0]     fold;
	logic              accept;
	logic              busy;

	assign accept = push && !full;
	assign full   = busy || hold;

	always_comb begin
		sum_d = '0;
		for (int j = 0; j < RED_STEPS; j++)
			sum_d = sum_d + SW'(NIB_RES[j][req_q.byte_address[RED_BITS*j +: RED_BITS]]);
	end

	always_comb begin
		fold = sum_q;
		for (int k = 2; k >= 0; k--) begin
			if (fold >= SW'(MEM_BYTES << k))
				fold = fold - SW'(MEM_BYTES << k);
		end
		op_base = fold[AW-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE: begin
				if (accept) state_d = F_REDUCE;
			end
			F_REDUCE: state_d = F_PUSH;
			F_PUSH: begin
				if (!op_full) state_d = F_IDLE;
			end
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		busy    = (state_q != F_IDLE);
		op_push = (state_q == F_PUSH) && !op_full;
		op.dest = req_q.dest_reg;
		op.data = req_q.data_value;
		op.sgn  = 1'b0;
		op.last = LAST_BYTE;
		op.kind = K_FAIL;
		unique case (req_q.command)
			CMD_LB: begin
				op.kind = K_LOAD;
				op.sgn  = 1'b1;
			end
			CMD_LH: begin
				op.kind = K_LOAD;
				op.sgn  = 1'b1;
				op.last = LAST_HALF;
			end
			CMD_LW: begin
				op.kind = K_LOAD;
				op.last = LAST_WORD;
			end
			CMD_LBU: op.kind = K_LOAD;
			CMD_LHU: begin
				op.kind = K_LOAD;
				op.last = LAST_HALF;
			end
			CMD_SB:  op.kind = K_STORE;
			CMD_SH: begin
				op.kind = K_STORE;
				op.last = LAST_HALF;
			end
			CMD_SW: begin
				op.kind = K_STORE;
				op.last = LAST_WORD;
			end
			CMD_PASS: op.kind = K_PASS;
			default:  op.kind = K_FAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= request;
		end
		if (state_q == F_REDUCE) begin
			sum_q <= sum_d;
		end
	end

endmodule

[design/lsbmu_back.sv]
// ----------------------------------------------------------------------------
// lsbmu_back
// Owns the data memory: clears it after reset, then carries out loads and
// stores one byte per cycle and forms the result word.
// ----------------------------------------------------------------------------
module lsbmu_back #(
	parameter int MEM_BYTES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          op_empty,
	output logic                          op_pop,
	input  lsbmu_pkg::op_t                op_in,
	input  logic [$clog2(MEM_BYTES)-1:0]  op_base,
	input  logic                          res_full,
	output logic                          res_push,
	output lsbmu_pkg::rsp_t               result,
	output logic                          clearing
);
	import lsbmu_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);

	logic [7:0]        mem [MEM_BYTES];
	bstate_t           state_q;
	bstate_t           state_d;
	op_t               op_q;
	logic [AW-1:0]     addr_q;
	logic [AW-1:0]     addr_nx;
	logic [AW-1:0]     clr_idx_q;
	logic [1:0]        lane_q;
	logic [1:0]        sel;
	logic [DATA_W-1:0] acc_q;
	logic [7:0]        rdata_s1;
	logic              rd_pend_s1;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [7:0]        mem_wdata;

	assign addr_nx = (addr_q == AW'(MEM_BYTES - 1)) ? '0 : addr_q + 1'b1;
	assign sel     = op_q.last - lane_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_CLEAR: begin
				if (clr_idx_q == AW'(MEM_BYTES - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (!op_empty) begin
					unique case (op_in.kind)
						K_LOAD:  state_d = B_LOAD;
						K_STORE: state_d = B_STORE;
						default: state_d = B_DONE;
					endcase
				end
			end
			B_LOAD: begin
				if (lane_q == op_q.last) state_d = B_LWAIT;
			end
			B_LWAIT: state_d = B_DONE;
			B_STORE: begin
				if (lane_q == op_q.last) state_d = B_DONE;
			end
			B_DONE: begin
				if (!res_full) state_d = B_IDLE;
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		clearing  = (state_q == B_CLEAR);
		op_pop    = (state_q == B_IDLE) && !op_empty;
		res_push  = (state_q == B_DONE) && !res_full;
		mem_we    = clearing || (state_q == B_STORE);
		mem_waddr = clearing ? clr_idx_q : addr_q;
		mem_wdata = clearing ? 8'h00 : op_q.data[{sel, 3'b000} +: 8];
		result    = '0;
		unique case (op_q.kind)
			K_LOAD: begin
				result.status = ST_WB;
				result.wb_reg = op_q.dest;
				unique case (op_q.last)
					LAST_BYTE: result.wb_value = {{24{op_q.sgn & acc_q[7]}}, acc_q[7:0]};
					LAST_HALF: result.wb_value = {{16{op_q.sgn & acc_q[15]}}, acc_q[15:0]};
					default:   result.wb_value = acc_q;
				endcase
			end
			K_STORE: result.status = ST_STORE;
			K_PASS: begin
				result.status   = ST_WB;
				result.wb_reg   = op_q.dest;
				result.wb_value = op_q.data;
			end
			default: result.status = ST_FAIL;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLEAR;
			clr_idx_q  <= '0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q    <= state_d;
			rd_pend_s1 <= (state_q == B_LOAD);
			if (clearing) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop) begin
			op_q   <= op_in;
			addr_q <= op_base;
			lane_q <= '0;
		end else if (state_q == B_LOAD || state_q == B_STORE) begin
			addr_q <= addr_nx;
			lane_q <= lane_q + 1'b1;
		end
		if (op_pop) begin
			acc_q <= '0;
		end else if (rd_pend_s1) begin
			acc_q <= {acc_q[DATA_W-9:0], rdata_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem[addr_q];
	end

	a_rd_pend: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == B_LOAD || state_q == B_LWAIT))
		else $error("read data arrives outside a load");

	a_lane_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_LOAD || state_q == B_STORE) |-> (lane_q <= op_q.last))
		else $error("byte lane past access size");

	a_clear_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clearing) |-> ($past(clr_idx_q) == AW'(MEM_BYTES - 1)))
		else $error("clear pass ended early");

endmodule

[design/load_store_byte_memory_unit.sv]
// ----------------------------------------------------------------------------
// load_store_byte_memory_unit
// Memory stage over a byte-addressed, big-endian data memory.
//
//   channel   | handshake    | word
//   request   | push / full  | command, dest_reg, byte_address, data_value
//   result    | pop / empty  | status, wb_reg, wb_value
//
// The front takes each request through accept, residue sum and hand-off, and
// takes no new request until the hand-off. The back works through a load or
// store byte by byte, with a wait after the last load read, and passes other
// words straight to a result, overlapped with the front through a 2-entry queue;
// the slower side sets the rate. After reset, full stays high while the memory clears.
// A full result queue stalls the back; a busy back stalls the front.
// ----------------------------------------------------------------------------
module load_store_byte_memory_unit #(
	parameter int MEM_BYTES = 4096
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  lsbmu_pkg::req_t request,
	input  logic            pop,
	output logic            empty,
	output lsbmu_pkg::rsp_t result
);
	import lsbmu_pkg::*;

	localparam int AW = $clog2(MEM_BYTES);
	localparam int OW = $bits(op_t) + AW;
	localparam int RW = $bits(rsp_t);

	op_t           f_op;
	logic [AW-1:0] f_base;
	logic          f_push;
	logic          opq_full;
	logic          opq_empty;
	logic [OW-1:0] opq_rdata;
	op_t           b_op;
	logic [AW-1:0] b_base;
	logic          b_pop;
	logic          clearing;
	rsp_t          b_res;
	logic          b_push;
	logic          resq_full;
	logic [RW-1:0] resq_rdata;

	assign b_op   = op_t'(opq_rdata[OW-1:AW]);
	assign b_base = opq_rdata[AW-1:0];
	assign result = rsp_t'(resq_rdata);

	lsbmu_front #(
		.MEM_BYTES(MEM_BYTES)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.hold    (clearing),
		.full    (full),
		.request (request),
		.op_push (f_push),
		.op_full (opq_full),
		.op      (f_op),
		.op_base (f_base)
	);

	lsbmu_queue #(
		.WIDTH(OW)
	) u_opq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.full   (opq_full),
		.wdata  ({f_op, f_base}),
		.pop    (b_pop),
		.empty  (opq_empty),
		.rdata  (opq_rdata)
	);

	lsbmu_back #(
		.MEM_BYTES(MEM_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (opq_empty),
		.op_pop   (b_pop),
		.op_in    (b_op),
		.op_base  (b_base),
		.res_full (resq_full),
		.res_push (b_push),
		.result   (b_res),
		.clearing (clearing)
	);

	lsbmu_queue #(
		.WIDTH(RW)
	) u_resq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.full   (resq_full),
		.wdata  (b_res),
		.pop    (pop),
		.empty  (empty),
		.rdata  (resq_rdata)
	);

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the load/store byte memory unit. A driver offers
// request words from a queue, and a monitor predicts each accepted word
// against a shadow copy of the big-endian data memory. Results are checked in
// order. Both handshakes see random gaps, and once the result side holds off
// long enough to back the unit up into its request port.
// ----------------------------------------------------------------------------
module tb;
	import lsbmu_pkg::*;

	localparam int MEM_BYTES  = 4096;
	localparam int RAND_WORDS = 2000;
	localparam int HOLD_AT    = 1000;
	localparam int HOLD_LEN   = 400;
	localparam int DRAIN_WAIT = 40;
	localparam int WATCHDOG   = 20000;

	localparam logic [CMD_W-1:0] CMD_BAD_LO = 4'd9;
	localparam logic [CMD_W-1:0] CMD_BAD_HI = 4'd15;

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	req_t request;
	logic pop;
	logic empty;
	rsp_t result;

	logic [7:0] shadow_mem [MEM_BYTES];
	req_t       pending_words [$];
	rsp_t       due_results [$];

	logic word_taken_q   = 1'b0;
	logic result_taken_q = 1'b0;
	int   send_gap       = 0;
	int   recv_gap       = 0;
	int   hold_left      = 0;
	bit   hold_done      = 1'b0;
	int   words_taken    = 0;
	int   results_seen   = 0;
	int   error_count    = 0;
	int   idle_cycles    = 0;
	int   full_stalls    = 0;
	int   loads_seen     = 0;
	int   stores_seen    = 0;
	int   passes_seen    = 0;
	int   unknown_seen   = 0;

	load_store_byte_memory_unit #(
		.MEM_BYTES(MEM_BYTES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.request(request),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic logic [31:0] fetch_be(int unsigned base, int unsigned nbytes);
		logic [31:0] v;
		v = '0;
		for (int unsigned k = 0; k < nbytes; k++)
			v = {v[23:0], shadow_mem[(base + k) % MEM_BYTES]};
		return v;
	endfunction

	function automatic void store_be(int unsigned base, logic [31:0] value,
		int unsigned nbytes);
		for (int unsigned k = 0; k < nbytes; k++)
			shadow_mem[(base + k) % MEM_BYTES] = 8'(value >> (8 * (nbytes - 1 - k)));
	endfunction

	function automatic rsp_t predict_access(req_t w);
		rsp_t        r;
		logic [31:0] v;
		int unsigned base;
		r        = '0;
		r.status = ST_WB;
		base     = w.byte_address % MEM_BYTES;
		case (w.command)
			CMD_LB, CMD_LBU: begin
				v = fetch_be(base, 1);
				r.wb_value = (w.command == CMD_LB) ? {{24{v[7]}}, v[7:0]} : v;
				loads_seen++;
			end
			CMD_LH, CMD_LHU: begin
				v = fetch_be(base, 2);
				r.wb_value = (w.command == CMD_LH) ? {{16{v[15]}}, v[15:0]} : v;
				loads_seen++;
			end
			CMD_LW: begin
				r.wb_value = fetch_be(base, 4);
				loads_seen++;
			end
			CMD_SB, CMD_SH, CMD_SW: begin
				store_be(base, w.data_value,
					(w.command == CMD_SB) ? 1 : (w.command == CMD_SH) ? 2 : 4);
				r.status = ST_STORE;
				stores_seen++;
			end
			CMD_PASS: begin
				r.wb_value = w.data_value;
				passes_seen++;
			end
			default: begin
				r.status = ST_FAIL;
				unknown_seen++;
			end
		endcase
		if (r.status == ST_WB)
			r.wb_reg = w.dest_reg;
		return r;
	endfunction

	function automatic int pick_gap(int count);
		int r;
		// hold a steady stream for one stretch in four
		if ((count / 150) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(21, 120);
	endfunction

	task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
				$time, field, want, got);
			error_count++;
		end
	endtask

	task automatic queue_access(logic [CMD_W-1:0] cmd, logic [REG_W-1:0] rd,
		logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
		req_t w;
		w.command      = cmd;
		w.dest_reg     = rd;
		w.byte_address = addr;
		w.data_value   = data;
		pending_words.push_back(w);
	endtask

	always @(posedge clk) begin : watch_ports
		rsp_t due;
		if (arst_n) begin
			word_taken_q   <= push && !full;
			result_taken_q <= pop && !empty;
			if (push && full)
				full_stalls++;
			if (push && !full) begin
				due_results.push_back(predict_access(request));
				words_taken++;
			end
			if (pop && !empty) begin
				results_seen++;
				if (due_results.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %p", $time, result);
					error_count++;
				end else begin
					due = due_results.pop_front();
					check_field("status", 32'(due.status), 32'(result.status));
					check_field("wb_reg", 32'(due.wb_reg), 32'(result.wb_reg));
					check_field("wb_value", due.wb_value, result.wb_value);
				end
			end
			if ((push && !full) || (pop && !empty))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("%0t: no handshake for %0d cycles", $time, WATCHDOG);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	always @(negedge clk) begin : drive_requests
		logic next_push;
		req_t next_req;
		if (arst_n) begin
			next_push = push;
			next_req  = request;
			// drop the word once taken, then advance after the gap
			if (push && word_taken_q) begin
				void'(pending_words.pop_front());
				next_push = 1'b0;
				send_gap  = pick_gap(words_taken);
			end
			if (!next_push) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_words.size() > 0) begin
					next_push = 1'b1;
					next_req  = pending_words[0];
				end
			end
			push    <= next_push;
			request <= next_req;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (result_taken_q)
				recv_gap = pick_gap(results_seen);
			if (!hold_done && words_taken >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	initial begin
		int               r;
		logic [CMD_W-1:0] cmd;
		logic [31:0]      addr;
		logic [31:0]      data;
		push    = 1'b0;
		pop     = 1'b0;
		request = '0;
		arst_n  = 1'b0;
		foreach (shadow_mem[i])
			shadow_mem[i] = 8'h00;

		queue_access(CMD_LW,   5'd31, 32'h0000_0000, 32'hFFFF_FFFF);
		queue_access(CMD_SW,   5'd0,  32'hFFFF_FFFE, 32'h8182_8384);
		queue_access(CMD_LW,   5'd1,  32'hFFFF_FFFE, 32'h0000_0000);
		queue_access(CMD_LB,   5'd2,  32'h0000_0FFE, 32'h0000_0000);
		queue_access(CMD_LBU,  5'd3,  32'h1234_5FFE, 32'h0000_0000);
		queue_access(CMD_LH,   5'd4,  32'hFFFF_FFFF, 32'h0000_0000);
		queue_access(CMD_LHU,  5'd5,  32'h0000_0FFF, 32'h0000_0000);
		queue_access(CMD_SH,   5'd31, 32'h0000_1001, 32'hFFFF_7F00);
		queue_access(CMD_LH,   5'd6,  32'h0000_0001, 32'h0000_0000);
		queue_access(CMD_LB,   5'd7,  32'h0000_0001, 32'h0000_0000);
		queue_access(CMD_SB,   5'd0,  32'h0000_0003, 32'hFFFF_FFFF);
		queue_access(CMD_LW,   5'd8,  32'h0000_0000, 32'h0000_0000);
		queue_access(CMD_SW,   5'd9,  32'h8000_0801, 32'h0000_0000);
		queue_access(CMD_SW,   5'd10, 32'h0000_07FF, 32'hFFFF_FFFF);
		queue_access(CMD_LW,   5'd11, 32'h0000_0801, 32'h0000_0000);
		queue_access(CMD_LHU,  5'd12, 32'h0000_07FF, 32'h0000_0000);
		queue_access(CMD_SB,   5'd13, 32'h0000_0100, 32'h1234_5680);
		queue_access(CMD_LB,   5'd14, 32'h0000_0100, 32'h0000_0000);
		queue_access(CMD_LBU,  5'd15, 32'h0000_0100, 32'h0000_0000);
		queue_access(CMD_PASS, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_access(CMD_PASS, 5'd0,  32'h0000_0000, 32'h0000_0000);
		queue_access(CMD_BAD_LO, 5'd16, 32'h0000_0100, 32'hDEAD_BEEF);
		queue_access(CMD_BAD_HI, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_access(CMD_LW,   5'd17, 32'h0000_0100, 32'h0000_0000);

		for (int n = 0; n < RAND_WORDS; n++) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				cmd = CMD_W'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
			else if (r < 10)
				cmd = CMD_PASS;
			else
				cmd = CMD_W'($urandom_range(CMD_LB, CMD_SW));
			// keep most accesses in two hot windows so loads see earlier stores
			addr = $urandom;
			r = $urandom_range(0, 99);
			if (r < 40)
				addr = (addr / MEM_BYTES) * MEM_BYTES + $urandom_range(0, 31);
			else if (r < 60)
				addr = (addr / MEM_BYTES) * MEM_BYTES
					+ $urandom_range(MEM_BYTES - 32, MEM_BYTES - 1);
			r = $urandom_range(0, 9);
			data = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? 32'h0000_0000 : 32'($urandom);
			queue_access(cmd, REG_W'($urandom_range(0, 31)), addr, data);
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() > 0 || due_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Run covered %0d requests: %0d loads, %0d stores, %0d passthrough, %0d unknown.",
			words_taken, loads_seen, stores_seen, passes_seen, unknown_seen);
		$display("%0d results checked; request port held back by full for %0d cycles.",
			results_seen, full_stalls);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
